[rtl/srs_pkg.sv]
`default_nettype none

package srs_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_POSITION = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // Timer value that marks a channel's release timer as stopped.
    localparam logic [15:0] TIMER_IDLE = 16'hFFFF;

    // Release delay used after reset, in milliseconds.
    localparam int unsigned DEFAULT_RELEASE_MS = 1000;

    // Classification of an incoming item, decided at the input.
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_POSITION = 2'd1,
        KIND_RELEASE  = 2'd2,
        KIND_TICK     = 2'd3
    } item_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic pos_write;
        logic div_mul;
        logic div_scale;
        logic div_write;
        logic sweep_step;
        logic emit;
    } srs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        item_kind_t kind;
        logic       sweep_last;
        logic       found;
        logic       out_free;
    } srs_status_t;

endpackage

`default_nettype wire

[rtl/srs_if.sv]
`default_nettype none

// Input item channel.
interface srs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  servo_number;
    logic [15:0] target_position;
    logic [15:0] target_speed;
    logic [15:0] release_ms;
    logic        release_off;

    modport source (
        output valid, command, servo_number, target_position, target_speed,
               release_ms, release_off,
        input  ready
    );
    modport sink (
        input  valid, command, servo_number, target_position, target_speed,
               release_ms, release_off,
        output ready
    );
endinterface

// Result item channel.
interface srs_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] target_register;
    logic [7:0] position_byte;

    modport source (
        output valid, target_register, position_byte,
        input  ready
    );
    modport sink (
        input  valid, target_register, position_byte,
        output ready
    );
endinterface

`default_nettype wire

[rtl/srs_ctrl.sv]
`default_nettype none

module srs_ctrl
    import srs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire srs_status_t status,
    output srs_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POS   = 7'b0000010,
        S_DIV1  = 7'b0000100,
        S_DIV2  = 7'b0001000,
        S_DIV3  = 7'b0010000,
        S_SWEEP = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    case (status.kind)
                        KIND_POSITION: state_next = S_POS;
                        KIND_RELEASE:  state_next = S_DIV1;
                        KIND_TICK:     state_next = S_SWEEP;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_POS:
            begin
                cmd.pos_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_DIV1:
            begin
                cmd.div_mul = 1'b1;
                state_next  = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_scale = 1'b1;
                state_next    = S_DIV3;
            end
            S_DIV3:
            begin
                cmd.div_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (!status.found || status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/srs_datapath.sv]
`default_nettype none

module srs_datapath
    import srs_pkg::*;
#(
    parameter int unsigned NUM_SERVOS     = 20,
    parameter int unsigned TICK_PERIOD_MS = 10
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    srs_in_if.sink     req,
    srs_out_if.source  rsp,
    input  wire srs_cmd_t cmd,
    output srs_status_t   status
);

    localparam int unsigned CH_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_SERVOS - 1);
    localparam logic [15:0] DEFAULT_TICKS = 16'(DEFAULT_RELEASE_MS / TICK_PERIOD_MS);
    // Reciprocal of the tick period scaled by 2^31; the quotient it gives is
    // exact or one low, which the remainder check corrects.
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / TICK_PERIOD_MS);
    localparam logic [15:0] DIVISOR = 16'(TICK_PERIOD_MS);

    // Per-channel state.
    logic [15:0]           user_pos_reg [NUM_SERVOS];
    logic [7:0]            drive_pos_reg [NUM_SERVOS];
    logic [15:0]           speed_reg [NUM_SERVOS];
    logic [15:0]           timer_reg [NUM_SERVOS];
    logic [15:0]           ticks_reg [NUM_SERVOS];
    logic [NUM_SERVOS-1:0] disabled_reg;
    logic [NUM_SERVOS-1:0] pending_reg;
    logic [CH_W-1:0]       last_reg;

    // Captured item.
    logic [CH_W-1:0] item_ch_reg;
    logic [15:0]     pos_reg;
    logic [15:0]     spd_reg;
    logic [15:0]     ms_reg;
    logic            off_reg;

    // Release duration conversion.
    logic [47:0] prod_reg;
    logic [15:0] quo_reg;
    logic [15:0] back_reg;
    logic [15:0] rem;
    logic [15:0] quo_fixed;

    // Sweep and round-robin search.
    logic [CH_W-1:0] sweep_ch_reg;
    logic [CH_W-1:0] sweep_ch_next;
    logic [CH_W-1:0] sweep_cnt_reg;
    logic [CH_W-1:0] start_ch;
    logic            found_reg;
    logic [CH_W-1:0] found_ch_reg;
    logic [7:0]      found_byte_reg;

    // Output register.
    logic       out_valid_reg;
    logic [4:0] out_target_reg;
    logic [7:0] out_byte_reg;

    logic            accept;
    logic            emit_load;
    logic            num_ok;
    item_kind_t      kind;
    logic [CH_W-1:0] addr;
    logic [15:0]     user_rd;
    logic [15:0]     speed_rd;
    logic [15:0]     timer_rd;
    logic [15:0]     ticks_rd;
    logic [7:0]      drive_rd;
    logic            dis_rd;
    logic            pend_rd;
    logic            pos_changed;
    logic            spd_changed;
    logic [15:0]     timer_inc;
    logic            timer_run;
    logic            expire;
    logic            pend_now;

    assign req.ready = cmd.in_ready;
    assign accept    = req.valid && cmd.in_ready;
    assign emit_load = cmd.emit && found_reg && status.out_free;

    // Classify the item offered at the input.
    assign num_ok = (req.servo_number != 5'd0) && (req.servo_number <= 5'(NUM_SERVOS));

    always_comb
    begin
        unique case (req.command)
            CMD_POSITION: kind = num_ok ? KIND_POSITION : KIND_NONE;
            CMD_RELEASE:  kind = num_ok ? KIND_RELEASE : KIND_NONE;
            CMD_TICK:     kind = KIND_TICK;
            default:      kind = KIND_NONE;
        endcase
    end

    assign status.kind       = kind;
    assign status.sweep_last = (sweep_cnt_reg == LAST_CH);
    assign status.found      = found_reg;
    assign status.out_free   = !out_valid_reg || rsp.ready;

    // One channel is addressed per cycle: the item's channel or the sweep's.
    assign addr      = cmd.sweep_step ? sweep_ch_reg : item_ch_reg;
    assign user_rd   = user_pos_reg[addr];
    assign speed_rd  = speed_reg[addr];
    assign timer_rd  = timer_reg[addr];
    assign ticks_rd  = ticks_reg[addr];
    assign drive_rd  = drive_pos_reg[addr];
    assign dis_rd    = disabled_reg[addr];
    assign pend_rd   = pending_reg[addr];

    assign pos_changed = (user_rd != pos_reg);
    assign spd_changed = (speed_rd != spd_reg);

    // A running timer advances; it expires once it passes the duration.
    assign timer_inc = timer_rd + 16'd1;
    assign timer_run = (timer_rd != TIMER_IDLE);
    assign expire    = timer_run && !dis_rd && (timer_inc > ticks_rd);
    assign pend_now  = pend_rd || expire;

    assign start_ch      = (last_reg == LAST_CH) ? '0 : last_reg + CH_W'(1);
    assign sweep_ch_next = (sweep_ch_reg == LAST_CH) ? '0 : sweep_ch_reg + CH_W'(1);

    // Remainder check of the reciprocal quotient.
    assign rem       = ms_reg - back_reg;
    assign quo_fixed = (rem >= DIVISOR) ? quo_reg + 16'd1 : quo_reg;

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ch_reg <= CH_W'(req.servo_number - 5'd1);
            pos_reg     <= req.target_position;
            spd_reg     <= req.target_speed;
            ms_reg      <= req.release_ms;
            off_reg     <= req.release_off;
        end
    end

    // Milliseconds to ticks: multiply, then scale back and correct.
    always_ff @(posedge clk)
    begin
        if (cmd.div_mul)
        begin
            prod_reg <= 48'(ms_reg) * 48'(RECIP);
        end
        if (cmd.div_scale)
        begin
            quo_reg  <= prod_reg[46:31];
            back_reg <= 16'(26'(prod_reg[46:31]) * 26'(DIVISOR));
        end
    end

    // Channel state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SERVOS; k++)
            begin
                user_pos_reg[k]  <= '0;
                drive_pos_reg[k] <= '0;
                speed_reg[k]     <= '0;
                timer_reg[k]     <= TIMER_IDLE;
                ticks_reg[k]     <= DEFAULT_TICKS;
            end
            disabled_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (cmd.pos_write)
            begin
                if (pos_changed)
                begin
                    user_pos_reg[addr]  <= pos_reg;
                    drive_pos_reg[addr] <= pos_reg[7:0];
                    if (!dis_rd)
                    begin
                        timer_reg[addr] <= '0;
                    end
                end
                if (spd_changed)
                begin
                    speed_reg[addr] <= spd_reg;
                end
                if (pos_changed || spd_changed)
                begin
                    pending_reg[addr] <= 1'b1;
                end
            end
            if (cmd.div_write)
            begin
                if (off_reg)
                begin
                    disabled_reg[addr] <= 1'b1;
                end
                else
                begin
                    disabled_reg[addr] <= 1'b0;
                    ticks_reg[addr]    <= quo_fixed;
                end
            end
            if (cmd.sweep_step && timer_run)
            begin
                if (expire)
                begin
                    timer_reg[addr]     <= TIMER_IDLE;
                    drive_pos_reg[addr] <= '0;
                    pending_reg[addr]   <= 1'b1;
                end
                else
                begin
                    timer_reg[addr] <= timer_inc;
                end
            end
            if (emit_load)
            begin
                pending_reg[found_ch_reg] <= 1'b0;
            end
        end
    end

    // Sweep position and the first pending channel after the last served.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_ch_reg  <= '0;
            sweep_cnt_reg <= '0;
            found_reg     <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                sweep_ch_reg  <= start_ch;
                sweep_cnt_reg <= '0;
                found_reg     <= 1'b0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_ch_reg  <= sweep_ch_next;
                sweep_cnt_reg <= sweep_cnt_reg + CH_W'(1);
                if (pend_now && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (emit_load)
            begin
                last_reg <= found_ch_reg;
            end
        end
    end

    // Channel and position byte of the search hit.
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step && pend_now && !found_reg)
        begin
            found_ch_reg   <= sweep_ch_reg;
            found_byte_reg <= expire ? 8'd0 : drive_rd;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_target_reg <= 5'(found_ch_reg) + 5'd1;
            out_byte_reg   <= found_byte_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.target_register = out_target_reg;
    assign rsp.position_byte   = out_byte_reg;

endmodule

`default_nettype wire

[rtl/servo_refresh_scheduler_unit.sv]
// Steps: a position item is captured, then written; a set-release item is captured, then multiplied,
// scaled back and corrected. A tick item sweeps the timers, visiting one channel per cycle,
// and finds the next pending channel on the way; its result follows in the output register.
// One item is in work at a time. A tick whose hit finds the output register still full
// holds in its last cycle, and keeps the input closed, until that register is taken.
// Reset (rst_n low, asynchronous) clears all channel state at once: positions and speeds zero,
// timers idle, durations at the default, nothing pending, no result held.
`default_nettype none

module servo_refresh_scheduler_unit
    import srs_pkg::*;
#(
    parameter int unsigned NUM_SERVOS     = 20,
    parameter int unsigned TICK_PERIOD_MS = 10
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    srs_in_if.sink    req,
    srs_out_if.source rsp
);

    srs_cmd_t    cmd;
    srs_status_t status;

    srs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .status   (status),
        .cmd      (cmd)
    );

    srs_datapath #(
        .NUM_SERVOS     (NUM_SERVOS),
        .TICK_PERIOD_MS (TICK_PERIOD_MS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

`ifndef SYNTHESIS
    // A reported register always names an existing channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.target_register != 5'd0 &&
                       rsp.target_register <= 5'(NUM_SERVOS)))
        else $error("result names a channel outside the bank");

    // A tick occupies the block for its sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_TICK) |=> !req.ready)
        else $error("input taken during a tick sweep");

    // A new result is never loaded over one still waiting to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.found && status.out_free) |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire
